>>> rtl/fid_pkg.sv
// Shared types and constants for the flux interval decoder.
`default_nettype none

package fid_pkg;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned NS_W      = 32;
  localparam int unsigned BAL_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [TICK_W-1:0] OVERFLOW_TICKS = 32'h0001_0000;
  localparam logic [NS_W-1:0]   SHORT_NS       = 32'd1000;
  localparam logic [BAL_W-1:0]  JITTER_LIMIT   = 12'd4;
  localparam logic [7:0]        NS_PER_TICK_RST = 8'd25;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_REV_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_REV      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_PER_TICK     = 2'd2;

  typedef struct packed {
    logic [15:0] flux_word;
    logic        rev_boundary;
    logic        wrap_to_first;
    logic [1:0]  rnd_jitter;
    logic        rnd_drop;
  } fid_in_t;

  typedef struct packed {
    logic [31:0] interval_ns;
    logic        index_mark;
  } fid_out_t;

endpackage

`default_nettype wire

>>> rtl/flux_interval_decoder_top.sv
// Flux interval decoder: tick words in, flux-reversal intervals in ns out.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | fid_in_t: word, flags, rnd bits
//  out_    | output    | out_valid/out_stall| fid_out_t: interval_ns, mark
//  cfg_    | input     | cfg_we             | cfg_idx selects reg, cfg_wdata
//
// One item per cycle sustained while no result is held by out_stall; a result
// reaches the result register after its item has passed through the input
// register. The state loop (pending/accumulated ticks, jitter balance) closes
// combinationally through the tick add, the 32x8 ns multiply and the drop compare.
// Zero words update state only and proceed even while a result waits.
// Reset (rst_n low, synchronous) clears state, valids and config to defaults.
// in_stall rises only when the input register is full and its nonzero word
// cannot move because the result register is held by out_stall.
`default_nettype none

module flux_interval_decoder_top
  import fid_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire fid_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output fid_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic signed [BAL_W-1:0] JLIM = $signed(JITTER_LIMIT);

  // config
  logic [TICK_W-1:0] total_r;
  logic              single_r;
  logic [7:0]        npt_r;

  // input register
  fid_in_t           in_r;
  logic              in_vld_r, in_vld_nxt;

  // state
  logic [TICK_W-1:0]       pend_r, pend_nxt;
  logic [TICK_W-1:0]       acc_r, acc_nxt;
  logic signed [BAL_W-1:0] bal_r, bal_nxt;
  logic                    idx_r, idx_nxt;

  // result register
  fid_out_t          out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  logic              in_accept, out_free, fire, emit, word_zero;
  logic [TICK_W-1:0] pend0, acc0, ticks0, ticks1;
  logic signed [BAL_W-1:0] half_src, adj, bal1;
  logic              big;
  logic [NS_W-1:0]   ns;
  logic              drop;

  assign word_zero = (in_r.flux_word == 16'd0);
  assign out_free  = !out_vld_r || !out_stall;
  assign fire      = in_vld_r && (word_zero || out_free);
  assign emit      = fire && !word_zero;
  assign in_stall  = in_vld_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_accept ? 1'b1 : (fire ? 1'b0 : in_vld_r);
    out_vld_nxt = emit ? 1'b1 : ((out_vld_r && !out_stall) ? 1'b0 : out_vld_r);
  end

  // Datapath for the item in the input register
  always_comb begin
    pend0 = pend_r;
    acc0  = acc_r;
    idx_nxt = idx_r;
    if (in_r.rev_boundary) begin
      idx_nxt = 1'b1;
      if (in_r.wrap_to_first) begin
        pend0 = total_r - acc_r;
        acc0  = acc_r - total_r;
      end
    end

    ticks0 = pend0 + {16'd0, in_r.flux_word};

    big      = (bal_r >= JLIM) || (bal_r <= -JLIM);
    // divide by two, truncating toward zero
    half_src = bal_r + $signed({{(BAL_W-1){1'b0}}, bal_r[BAL_W-1]});
    if (big)
      adj = half_src >>> 1;
    else if (in_r.rnd_jitter[1])
      adj = in_r.rnd_jitter[0] ? 12'sd1 : -12'sd1;
    else
      adj = 12'sd0;

    if (single_r) begin
      bal1   = bal_r - adj;
      ticks1 = ticks0 + {{(TICK_W-BAL_W){adj[BAL_W-1]}}, adj};
    end else begin
      bal1   = bal_r;
      ticks1 = ticks0;
    end

    ns   = ticks1 * {{(NS_W-8){1'b0}}, npt_r};
    drop = single_r && (ns < SHORT_NS) && in_r.rnd_drop;

    out_nxt.index_mark  = idx_nxt;
    out_nxt.interval_ns = drop ? '0 : ns;

    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    bal_nxt  = bal_r;
    if (fire) begin
      if (word_zero) begin
        pend_nxt = pend0 + OVERFLOW_TICKS;
        acc_nxt  = acc0;
      end else begin
        pend_nxt = '0;
        acc_nxt  = acc0 + ticks0;
        bal_nxt  = drop ? (bal1 + $signed({2'b00, ns[9:0]})) : bal1;
        idx_nxt  = 1'b0;
      end
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      single_r  <= 1'b0;
      npt_r     <= NS_PER_TICK_RST;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pend_r    <= '0;
      acc_r     <= '0;
      bal_r     <= '0;
      idx_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TOTAL_REV_TICKS: total_r  <= cfg_wdata;
          CFG_SINGLE_REV:      single_r <= cfg_wdata[0];
          CFG_NS_PER_TICK:     npt_r    <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      pend_r    <= pend_nxt;
      acc_r     <= acc_nxt;
      bal_r     <= bal_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) in_r <= in_data;
    if (emit) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Assertions
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_vld_r)
    else $error("nonzero word did not produce a result");

  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (pend_r == '0) && !idx_r)
    else $error("pending ticks or index not cleared after a result");

  a_bal_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !single_r |=> $stable(bal_r))
    else $error("jitter balance moved outside single revolution mode");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall && !word_zero)
    else $error("input stalled without a blocked result");

  a_zero_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && word_zero && !out_vld_r |=> !out_vld_r)
    else $error("zero word produced a result");

endmodule

`default_nettype wire

>>> verif/fid_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Interval predictor and result scoreboard for the flux interval decoder bench.
package fid_scoreboard_pkg;
  import fid_pkg::*;

  class interval_scoreboard;
    logic [31:0]        total_rev_ticks;
    logic               single_rev;
    logic [7:0]         ns_per_tick;
    logic [31:0]        pending_ticks;
    logic [31:0]        accum_ticks;
    logic signed [11:0] jitter_bal;
    logic               index_pend;
    fid_out_t           expected_q[$];
    int unsigned        errors;

    function new();
      total_rev_ticks = '0;
      single_rev      = 1'b0;
      ns_per_tick     = NS_PER_TICK_RST;
      pending_ticks   = '0;
      accum_ticks     = '0;
      jitter_bal      = '0;
      index_pend      = 1'b0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_TOTAL_REV_TICKS: total_rev_ticks = data;
        CFG_SINGLE_REV:      single_rev = data[0];
        CFG_NS_PER_TICK:     ns_per_tick = data[7:0];
        default: ;
      endcase
    endfunction

    // Accepted input item: update the decoder state, queue the interval it yields.
    function void note_input(fid_in_t it);
      logic [31:0] ticks;
      logic [31:0] ns;
      int          bal;
      int          adj;
      fid_out_t    res;
      if (it.rev_boundary) begin
        index_pend = 1'b1;
        if (it.wrap_to_first) begin
          // leftover revolution time goes to the next interval
          pending_ticks = total_rev_ticks - accum_ticks;
          accum_ticks   = -pending_ticks;
        end
      end
      if (it.flux_word == '0) begin
        pending_ticks += OVERFLOW_TICKS;
        return;
      end
      ticks = pending_ticks + 32'(it.flux_word);
      pending_ticks = '0;
      accum_ticks += ticks;
      if (single_rev) begin
        bal = jitter_bal;
        if (bal >= int'(JITTER_LIMIT) || bal <= -int'(JITTER_LIMIT)) adj = bal / 2;
        else if (it.rnd_jitter[0]) adj = int'(it.rnd_jitter[1]);
        else adj = -int'(it.rnd_jitter[1]);
        jitter_bal = 12'(bal - adj);
        ticks += 32'(adj);
      end
      ns = ticks * 32'(ns_per_tick);
      if (single_rev && ns < SHORT_NS && it.rnd_drop) begin
        jitter_bal = 12'(int'(jitter_bal) + int'(ns));
        ns = '0;
      end
      res.interval_ns = ns;
      res.index_mark  = index_pend;
      index_pend = 1'b0;
      expected_q.push_back(res);
    endfunction

    function void check_result(fid_out_t got);
      fid_out_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected item: interval_ns %0d index_mark %0b",
               got.interval_ns, got.index_mark);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.interval_ns !== want.interval_ns) begin
        $error("interval_ns: expected %0d, got %0d", want.interval_ns, got.interval_ns);
        errors++;
      end
      if (got.index_mark !== want.index_mark) begin
        $error("index_mark: expected %0b, got %0b", want.index_mark, got.index_mark);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level bench: drives flux words and config, checks decoded intervals.
module tb_top;
  import fid_pkg::*;
  import fid_scoreboard_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 60;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  fid_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  fid_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  bit quiet;
  bit hold_req;
  interval_scoreboard sb;

  flux_interval_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // mostly short idles, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic fid_in_t flux_item(logic [15:0] word, logic bnd, logic wrap,
                                        logic [1:0] rj, logic rd);
    fid_in_t it;
    it.flux_word     = word;
    it.rev_boundary  = bnd;
    it.wrap_to_first = wrap;
    it.rnd_jitter    = rj;
    it.rnd_drop      = rd;
    return it;
  endfunction

  // mostly plausible flux streams; some items fully random
  function automatic fid_in_t random_flux_item();
    fid_in_t     it;
    int unsigned r;
    it = flux_item(16'($urandom), 1'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) >= 15) begin
      r = $urandom_range(0, 99);
      if (r < 10) it.flux_word = '0;
      else if (r < 25) it.flux_word = 16'($urandom_range(1, 40));
      else if (r < 90) it.flux_word = 16'($urandom_range(40, 400));
      else it.flux_word = 16'($urandom_range(401, 65535));
      it.rev_boundary  = ($urandom_range(0, 29) == 0);
      it.wrap_to_first = it.rev_boundary && ($urandom_range(0, 1) == 1);
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // result side back-pressure
  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        n = LONG_HOLD;
      end else begin
        n = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
      end
      out_stall <= (n > 0);
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_item(fid_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_gap();
    int unsigned n;
    n = (quiet || $urandom_range(0, 1) == 1) ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending until every queued interval is out, then let zero words settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] total, logic single, logic [7:0] npt);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TOTAL_REV_TICKS;
    cfg_wdata <= total;
    @(posedge clk);
    cfg_idx   <= CFG_SINGLE_REV;
    cfg_wdata <= 32'(single);
    @(posedge clk);
    cfg_idx   <= CFG_NS_PER_TICK;
    cfg_wdata <= 32'(npt);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_TOTAL_REV_TICKS, total);
    sb.write_reg(CFG_SINGLE_REV, 32'(single));
    sb.write_reg(CFG_NS_PER_TICK, 32'(npt));
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: no jitter, 25 ns per tick, zero total
    send_item(flux_item(16'd1, 1'b0, 1'b0, 2'd0, 1'b0));
    send_item(flux_item(16'hFFFF, 1'b0, 1'b0, 2'd3, 1'b1));
    send_item(flux_item(16'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    send_item(flux_item(16'd5, 1'b0, 1'b0, 2'd0, 1'b0));
    send_item(flux_item(16'd0, 1'b0, 1'b0, 2'd1, 1'b0));
    send_item(flux_item(16'd0, 1'b0, 1'b0, 2'd2, 1'b0));
    send_item(flux_item(16'h8000, 1'b0, 1'b0, 2'd0, 1'b0));
    send_item(flux_item(16'd100, 1'b1, 1'b0, 2'd0, 1'b0));
    // wrap on an overflow word, donation lands on the next interval
    send_item(flux_item(16'd0, 1'b1, 1'b1, 2'd0, 1'b0));
    send_item(flux_item(16'd10, 1'b0, 1'b0, 2'd0, 1'b0));
    // wrap flag without a boundary is ignored
    send_item(flux_item(16'd7, 1'b0, 1'b1, 2'd0, 1'b0));
    send_item(flux_item(16'd3, 1'b0, 1'b0, 2'd0, 1'b1));

    set_config(32'd5000, 1'b1, 8'd25);
    send_item(flux_item(16'd200, 1'b0, 1'b0, 2'd0, 1'b0));
    send_item(flux_item(16'd200, 1'b0, 1'b0, 2'd1, 1'b0));
    send_item(flux_item(16'd200, 1'b0, 1'b0, 2'd2, 1'b0));
    send_item(flux_item(16'd200, 1'b0, 1'b0, 2'd3, 1'b0));
    // short pulse dropped into the balance, then the balance gets halved
    send_item(flux_item(16'd10, 1'b0, 1'b0, 2'd1, 1'b1));
    send_item(flux_item(16'd10, 1'b0, 1'b0, 2'd1, 1'b0));
    send_item(flux_item(16'd30, 1'b0, 1'b0, 2'd2, 1'b1));
    send_item(flux_item(16'd300, 1'b0, 1'b0, 2'd3, 1'b1));
    send_item(flux_item(16'd120, 1'b1, 1'b1, 2'd0, 1'b0));
    send_item(flux_item(16'd0, 1'b1, 1'b0, 2'd0, 1'b0));
    send_item(flux_item(16'd50, 1'b0, 1'b0, 2'd1, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(32'hFFFF_FFFF, 1'b1, 8'd255);
        1: set_config(32'd0, 1'b1, 8'd1);
        2: set_config($urandom, 1'b0, 8'd0);
        default: set_config($urandom, 1'($urandom), 8'($urandom_range(1, 255)));
      endcase
      quiet = (ph % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver sits on its stall while the sender keeps pushing
        if (ph == 5 && i == 5) hold_req = 1'b1;
        if (ph == 4 && i == 30) wait_drain();
        send_item(random_flux_item());
        sender_gap();
      end
    end

    wait_drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
